/* rtl/rnv_pkg.sv */
// Shared types, constants and the arctangent table for the vector rotate/normalize pipeline.
package rnv_pkg;

  localparam int TabLen = 24;
  localparam int DpW = 34;
  localparam logic signed [DpW-1:0] KinvQ30 = 34'sd652032874;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;

  // Per-item side data carried down the whole chain
  typedef struct packed {
    logic        vld;
    logic        grp;
    logic        zl;
    logic [15:0] px;
    logic [15:0] py;
    logic [15:0] ang;
  } side_t;

  // Vectoring cell payload
  typedef struct packed {
    logic signed [DpW-1:0] x;
    logic signed [DpW-1:0] y;
    logic [31:0]           z;
  } vec_t;

  // Rotation cell payload
  typedef struct packed {
    logic signed [DpW-1:0] x;
    logic signed [DpW-1:0] y;
    logic signed [DpW-1:0] r;
    logic                  flip;
  } rot_t;

  // round(atan(2^-i) * 2^32 / 2pi)
  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/rnv_vec_cell.sv */
// One vectoring micro-rotation cell: drives y toward zero and accumulates the angle.
module rnv_vec_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rnv_pkg::side_t  side_i,
  input  rnv_pkg::vec_t   d_i,
  output rnv_pkg::side_t  side_o,
  output rnv_pkg::vec_t   d_o
);

  localparam logic [31:0] Atan = rnv_pkg::atan_val(STAGE[4:0]);

  rnv_pkg::side_t side_r;
  rnv_pkg::vec_t  d_r, d_nxt;

  // micro-rotation, direction chosen by the sign of y
  always_comb begin
    if (d_i.y > 0) begin
      d_nxt.x = d_i.x + (d_i.y >>> STAGE);
      d_nxt.y = d_i.y - (d_i.x >>> STAGE);
      d_nxt.z = d_i.z + Atan;
    end else begin
      d_nxt.x = d_i.x - (d_i.y >>> STAGE);
      d_nxt.y = d_i.y + (d_i.x >>> STAGE);
      d_nxt.z = d_i.z - Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r.vld <= side_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.grp <= side_i.grp;
      side_r.zl  <= side_i.zl;
      side_r.px  <= side_i.px;
      side_r.py  <= side_i.py;
      side_r.ang <= side_i.ang;
      d_r        <= d_nxt;
    end
  end

  assign side_o = side_r;
  assign d_o    = d_r;

endmodule

/* rtl/rnv_rot_cell.sv */
// One rotation micro-rotation cell: drives the residual angle toward zero.
module rnv_rot_cell #(
  parameter int STAGE = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  rnv_pkg::side_t  side_i,
  input  rnv_pkg::rot_t   d_i,
  output rnv_pkg::side_t  side_o,
  output rnv_pkg::rot_t   d_o
);

  localparam logic signed [rnv_pkg::DpW-1:0] Atan =
    $signed({2'b00, rnv_pkg::atan_val(STAGE[4:0])});

  rnv_pkg::side_t side_r;
  rnv_pkg::rot_t  d_r, d_nxt;

  // micro-rotation, direction chosen by the sign of the residual
  always_comb begin
    d_nxt.flip = d_i.flip;
    if (d_i.r >= 0) begin
      d_nxt.x = d_i.x - (d_i.y >>> STAGE);
      d_nxt.y = d_i.y + (d_i.x >>> STAGE);
      d_nxt.r = d_i.r - Atan;
    end else begin
      d_nxt.x = d_i.x + (d_i.y >>> STAGE);
      d_nxt.y = d_i.y - (d_i.x >>> STAGE);
      d_nxt.r = d_i.r + Atan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r.vld <= 1'b0;
    end else if (en) begin
      side_r.vld <= side_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r.grp <= side_i.grp;
      side_r.zl  <= side_i.zl;
      side_r.px  <= side_i.px;
      side_r.py  <= side_i.py;
      side_r.ang <= side_i.ang;
      d_r        <= d_nxt;
    end
  end

  assign side_o = side_r;
  assign d_o    = d_r;

endmodule

/* rtl/rotate_and_normalize_2d_vector.sv */
// Rotate a 2D direction vector by a binary angle and normalize it to unit length.
//
// Input beat: in_tdata carries dir_x, dir_y (signed Q1.15) and angle (65536 units
// per turn); in_tuser carries in_group. Output beat: out_tdata carries out_x,
// out_y (Q1.15, saturated to -32768..+32767); out_tuser carries zero_length.
// Items outside the group pass through unchanged; a (0,0) vector in the group
// gives (0,0) with zero_length set.
// The datapath is a row of N vectoring cells (finds the input direction), one
// register that adds the rotation angle and folds it into the right half plane,
// a row of N rotation cells started from the inverse CORDIC gain, and an output
// register that rounds and saturates. N = min(CORDIC_STAGES, 24).
// One beat is taken every cycle while the output is not stalled, the cell chain
// advancing once per clock while it is enabled.
// When the receiver holds out_tready low with a beat waiting, the whole chain
// freezes and in_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every valid flag in the chain and the output valid.
module rotate_and_normalize_2d_vector #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // dir_x, dir_y, angle
  input  logic        in_tuser,   // in_group
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // out_x, out_y
  output logic        out_tuser   // zero_length
);

  localparam int N = (CORDIC_STAGES > rnv_pkg::TabLen) ? rnv_pkg::TabLen : CORDIC_STAGES;
  localparam int W = rnv_pkg::DpW;

  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // input split and vectoring preconditioning
  logic signed [15:0] dx, dy;
  logic signed [W-1:0] xs, ys;
  rnv_pkg::side_t vside [0:N];
  rnv_pkg::vec_t  vdat  [0:N];

  assign dx = in_tdata[15:0];
  assign dy = in_tdata[31:16];
  assign xs = W'(dx) <<< 14;
  assign ys = W'(dy) <<< 14;

  always_comb begin
    vside[0].vld = in_tvalid;
    vside[0].grp = in_tuser;
    vside[0].zl  = (dx == 16'sd0) && (dy == 16'sd0);
    vside[0].px  = in_tdata[15:0];
    vside[0].py  = in_tdata[31:16];
    vside[0].ang = in_tdata[47:32];
    if (dx < 0) begin
      vdat[0].x = -xs;
      vdat[0].y = -ys;
      vdat[0].z = rnv_pkg::HalfTurn;
    end else begin
      vdat[0].x = xs;
      vdat[0].y = ys;
      vdat[0].z = 32'd0;
    end
  end

  // vectoring chain
  for (genvar i = 0; i < N; i++) begin : g_vec
    rnv_vec_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(vside[i]), .d_i(vdat[i]),
      .side_o(vside[i+1]), .d_o(vdat[i+1])
    );
  end

  // angle add and half-plane fold
  logic [31:0] zt;
  logic        flip;
  logic [31:0] zf;
  rnv_pkg::side_t mside_r;
  rnv_pkg::rot_t  mdat_nxt, mdat_r;
  rnv_pkg::side_t rside [0:N];
  rnv_pkg::rot_t  rdat  [0:N];

  always_comb begin
    zt   = vdat[N].z + {vside[N].ang, 16'd0};
    flip = (zt >= rnv_pkg::QuarterTurn) && (zt < rnv_pkg::HalfTurn + rnv_pkg::QuarterTurn);
    zf   = flip ? (zt - rnv_pkg::HalfTurn) : zt;
    mdat_nxt.x    = rnv_pkg::KinvQ30;
    mdat_nxt.y    = '0;
    mdat_nxt.r    = W'($signed(zf));
    mdat_nxt.flip = flip;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mside_r.vld <= 1'b0;
    end else if (en) begin
      mside_r.vld <= vside[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mside_r.grp <= vside[N].grp;
      mside_r.zl  <= vside[N].zl;
      mside_r.px  <= vside[N].px;
      mside_r.py  <= vside[N].py;
      mside_r.ang <= vside[N].ang;
      mdat_r      <= mdat_nxt;
    end
  end

  assign rside[0] = mside_r;
  assign rdat[0]  = mdat_r;

  // rotation chain
  for (genvar i = 0; i < N; i++) begin : g_rot
    rnv_rot_cell #(.STAGE(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .side_i(rside[i]), .d_i(rdat[i]),
      .side_o(rside[i+1]), .d_o(rdat[i+1])
    );
  end

  // sign fix, rounding to Q1.15, saturation and result select
  function automatic logic [15:0] rnd_sat(input logic signed [W-1:0] v);
    logic signed [W-1:0] t;
    t = (v + W'(16384)) >>> 15;
    if (t > W'(32767)) begin
      return 16'h7FFF;
    end else if (t < -W'(32768)) begin
      return 16'h8000;
    end
    return t[15:0];
  endfunction

  logic signed [W-1:0] fx, fy;
  logic        ovld_r;
  logic [15:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic        ozl_r, ozl_nxt;

  always_comb begin
    fx = rdat[N].flip ? -rdat[N].x : rdat[N].x;
    fy = rdat[N].flip ? -rdat[N].y : rdat[N].y;
    if (!rside[N].grp) begin
      ox_nxt  = rside[N].px;
      oy_nxt  = rside[N].py;
      ozl_nxt = 1'b0;
    end else if (rside[N].zl) begin
      ox_nxt  = '0;
      oy_nxt  = '0;
      ozl_nxt = 1'b1;
    end else begin
      ox_nxt  = rnd_sat(fx);
      oy_nxt  = rnd_sat(fy);
      ozl_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= rside[N].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox_r  <= ox_nxt;
      oy_r  <= oy_nxt;
      ozl_r <= ozl_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {oy_r, ox_r};
  assign out_tuser  = ozl_r;

endmodule

/* tb/tb_rotate_and_normalize_2d_vector.sv */
// Testbench for the 2D vector rotate/normalize pipeline: directed and random beats checked
// against a bit-true fixed-point CORDIC predictor.
`timescale 1ns / 100ps

module tb_rotate_and_normalize_2d_vector;

  localparam int Stages = 16;
  localparam int NumRandom = 1225;
  localparam int StallLimit = 20000;
  localparam int DrainCycles = 2 * Stages + 20;
  localparam logic [31:0] HalfTurnB = 32'h8000_0000;
  localparam logic [31:0] QuarterTurnB = 32'h4000_0000;
  localparam longint KinvQ30 = 652032874;

  typedef struct packed {
    logic [15:0] vx;
    logic [15:0] vy;
    logic        zl;
  } unit_res_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // dir_x, dir_y, angle
  logic        in_tuser;   // in_group
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // out_x, out_y
  logic        out_tuser;  // zero_length

  unit_res_t expected_q[$];
  int        err_cnt;
  int        beats_in;
  int        beats_out;
  int        n_group;
  int        n_zero;
  int        idle_cycles;
  bit        busy_mode;   // 1 = idle at random on both sides
  bit        done_tx;

  rotate_and_normalize_2d_vector #(.CORDIC_STAGES(Stages)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // Clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Table of round(atan(2^-i) * 2^32 / 2pi)
  function automatic longint atan_units(input int i);
    longint t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772,
                      166886, 83443, 41722, 20861, 10430, 5215,
                      2608, 1304, 652, 326, 163, 81};
    return t[i];
  endfunction

  function automatic longint clamp_q15(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Bit-true prediction of one result beat
  function automatic unit_res_t predict_unit(input logic signed [15:0] dx,
                                             input logic signed [15:0] dy,
                                             input logic [15:0] ang,
                                             input logic grp);
    unit_res_t   r;
    longint      x, y, nx, ny, rr;
    logic [31:0] z;
    bit          flip;
    int          n;
    n = (Stages > 24) ? 24 : Stages;
    r = '0;
    if (!grp) begin
      r.vx = dx;
      r.vy = dy;
      return r;
    end
    if (dx == 0 && dy == 0) begin
      r.zl = 1'b1;
      return r;
    end
    // find the input direction
    x = longint'(dx) * 16384;
    y = longint'(dy) * 16384;
    z = '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HalfTurnB;
    end
    for (int i = 0; i < n; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + 32'(atan_units(i));
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - 32'(atan_units(i));
      end
      x = nx;
      y = ny;
    end
    // rotate a gain-compensated unit vector to the target direction
    z = z + {ang, 16'h0000};
    flip = 1'b0;
    if (z >= QuarterTurnB && z < QuarterTurnB * 3) begin
      flip = 1'b1;
      z = z - HalfTurnB;
    end
    rr = longint'($signed(z));
    x = KinvQ30;
    y = 0;
    for (int i = 0; i < n; i++) begin
      if (rr >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        rr = rr - atan_units(i);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        rr = rr + atan_units(i);
      end
      x = nx;
      y = ny;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    r.vx = 16'(clamp_q15((x + 16384) >>> 15));
    r.vy = 16'(clamp_q15((y + 16384) >>> 15));
    return r;
  endfunction

  // Send one beat and record its expected result; valid stays high between
  // back-to-back beats and drops only in idle cycles
  task automatic send_vec(input logic [15:0] dx, input logic [15:0] dy,
                          input logic [15:0] ang, input logic grp);
    while (busy_mode && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, dy, dx};
    in_tuser <= grp;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(predict_unit(dx, dy, ang, grp));
    beats_in++;
    if (grp) n_group++;
    if (grp && dx == 0 && dy == 0) n_zero++;
    @(negedge clk);
  endtask

  // Result checker
  always @(posedge clk) begin
    unit_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      beats_out++;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat %h/%b", out_tdata, out_tuser);
        err_cnt++;
      end else begin
        e = expected_q.pop_front();
        if (out_tdata[15:0] !== e.vx) begin
          $error("out_x expected %0d got %0d", $signed(e.vx), $signed(out_tdata[15:0]));
          err_cnt++;
        end
        if (out_tdata[31:16] !== e.vy) begin
          $error("out_y expected %0d got %0d", $signed(e.vy), $signed(out_tdata[31:16]));
          err_cnt++;
        end
        if (out_tuser !== e.zl) begin
          $error("zero_length expected %0b got %0b", e.zl, out_tuser);
          err_cnt++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_tready <= busy_mode ? ($urandom_range(99) >= 20) : 1'b1;
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || done_tx)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic test_extremes();
    logic [15:0] ends[5] = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    for (int i = 0; i < 5; i++)
      send_vec(ends[i], ends[4 - i], 16'hFFFF - 16'(i), 1'b1);
    send_vec(16'h8000, 16'h8000, 16'h0000, 1'b1);
    send_vec(16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
  endtask

  task automatic test_pass_through();
    send_vec(16'h8000, 16'h7FFF, 16'h1234, 1'b0);
    send_vec(16'h0000, 16'h0000, 16'hFFFF, 1'b0);
    send_vec(16'h5A5A, 16'hA5A5, 16'h0000, 1'b0);
  endtask

  task automatic test_zero_length();
    send_vec(16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_vec(16'h0000, 16'h0000, 16'hC000, 1'b1);
  endtask

  task automatic test_left_half_plane();
    send_vec(16'hC000, 16'h1000, 16'h0000, 1'b1);
    send_vec(16'hC000, 16'hF000, 16'h2000, 1'b1);
    send_vec(16'h8000, 16'h0000, 16'h4000, 1'b1);
  endtask

  task automatic test_folded_target();
    // targets near a quarter and three quarters of a turn, and inside the folded span
    send_vec(16'h4000, 16'h0000, 16'h4000, 1'b1);
    send_vec(16'h4000, 16'h0000, 16'h3FFF, 1'b1);
    send_vec(16'h4000, 16'h0000, 16'hC000, 1'b1);
    send_vec(16'h4000, 16'h0000, 16'hBFFF, 1'b1);
    send_vec(16'h2000, 16'h2000, 16'h8000, 1'b1);
    send_vec(16'h0000, 16'h4000, 16'h2000, 1'b1);
  endtask

  task automatic test_random(input int count);
    logic [15:0] dx, dy;
    for (int i = 0; i < count; i++) begin
      busy_mode = !(i >= count / 3 && i < count / 2);
      dx = 16'($urandom);
      dy = 16'($urandom);
      case ($urandom_range(9))
        0: dx = 16'($signed(4'($urandom)));
        1: dy = 16'($signed(4'($urandom)));
        2: begin
          dx = '0;
          dy = '0;
        end
        default: ;
      endcase
      send_vec(dx, dy, 16'($urandom), $urandom_range(9) != 0);
    end
    busy_mode = 1'b1;
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    err_cnt = 0;
    beats_in = 0;
    beats_out = 0;
    n_group = 0;
    n_zero = 0;
    idle_cycles = 0;
    busy_mode = 1'b1;
    done_tx = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_pass_through();
    test_zero_length();
    test_left_half_plane();
    test_folded_target();
    test_random(NumRandom);
    in_tvalid <= 1'b0;

    // drain
    while (expected_q.size() != 0) @(posedge clk);
    done_tx = 1'b1;
    waited = 0;
    while (waited < DrainCycles) begin
      @(posedge clk);
      waited++;
    end

    $display("Sent %0d beats (%0d in group, %0d zero-length), checked %0d results.",
             beats_in, n_group, n_zero, beats_out);
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/rnv_pkg.sv
rtl/rnv_vec_cell.sv
rtl/rnv_rot_cell.sv
rtl/rotate_and_normalize_2d_vector.sv
tb/tb_rotate_and_normalize_2d_vector.sv
